>>> hw/rtl/dglcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dglcd_pkg
// Shared types, codes and constants of the two-half graphic LCD controller.
// ----------------------------------------------------------------------------
package dglcd_pkg;

    localparam int DEF_COLUMNS = 64;
    localparam int DEF_PAGES   = 8;
    localparam int DEF_HALVES  = 2;

    // Bus access modes.
    typedef enum logic [1:0] {
        MODE_INS_WR    = 2'd0,
        MODE_DATA_WR   = 2'd1,
        MODE_STATUS_RD = 2'd2,
        MODE_DATA_RD   = 2'd3
    } t_mode;

    // Instruction decode.
    typedef enum logic [2:0] {
        INS_NONE,
        INS_DISPLAY,
        INS_COLUMN,
        INS_PAGE,
        INS_START
    } t_ins;

    localparam logic [7:0] INS_DISP_MASK = 8'hFE;
    localparam logic [7:0] INS_DISP_CODE = 8'h3E;
    localparam logic [7:0] INS_COL_MASK  = 8'hC0;
    localparam logic [7:0] INS_COL_CODE  = 8'h40;
    localparam logic [7:0] INS_PAGE_MASK = 8'hF8;
    localparam logic [7:0] INS_PAGE_CODE = 8'hB8;
    localparam logic [7:0] INS_LINE_MASK = 8'hC0;
    localparam logic [7:0] INS_LINE_CODE = 8'hC0;
    localparam logic [7:0] ARG6_MASK     = 8'h3F;
    localparam logic [7:0] ARG3_MASK     = 8'h07;

    // Status byte bits. Busy and reset always read as zero.
    localparam logic [7:0] STAT_BUSY  = 8'h80;
    localparam logic [7:0] STAT_OFF   = 8'h20;
    localparam logic [7:0] STAT_RESET = 8'h10;

    // Controller sequencer states.
    typedef enum logic {
        S_IDLE,
        S_FILL
    } t_state;

    // Display RAM strobes.
    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

    typedef logic [5:0] t_mod_tab [64];

    // Residue table built at elaboration by a wrapping counter.
    function automatic t_mod_tab mod_table(input int m);
        t_mod_tab   tab;
        logic [5:0] cnt;
        cnt = 6'd0;
        for (int i = 0; i < 64; i++) begin
            tab[i] = cnt;
            cnt    = (32'(cnt) + 1 == m) ? 6'd0 : cnt + 6'd1;
        end
        return tab;
    endfunction

    function automatic t_ins decode_ins(input logic [7:0] b);
        priority if ((b & INS_DISP_MASK) == INS_DISP_CODE) return INS_DISPLAY;
        else if ((b & INS_COL_MASK) == INS_COL_CODE)       return INS_COLUMN;
        else if ((b & INS_PAGE_MASK) == INS_PAGE_CODE)     return INS_PAGE;
        else if ((b & INS_LINE_MASK) == INS_LINE_CODE)     return INS_START;
        else                                               return INS_NONE;
    endfunction

endpackage

>>> hw/rtl/dglcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dglcd_if
// Bus access channel and read response channel of the LCD controller.
// ----------------------------------------------------------------------------
interface dglcd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       chip;
    logic [7:0] bus_byte;

    modport source (output valid, output mode, output chip, output bus_byte, input ready);
    modport sink   (input valid, input mode, input chip, input bus_byte, output ready);
endinterface

interface dglcd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;

    modport source (output valid, output read_byte, input ready);
    modport sink   (input valid, input read_byte, output ready);
endinterface

>>> hw/rtl/dglcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dglcd_ram
// Single-port display RAM with a registered read port.
// ----------------------------------------------------------------------------
module dglcd_ram
    import dglcd_pkg::*;
#(
    parameter int DEPTH  = DEF_HALVES * DEF_PAGES * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  t_ram_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dglcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dglcd_ctrl
// Per-half register file, instruction decode, read latch and result register.
// ----------------------------------------------------------------------------
module dglcd_ctrl
    import dglcd_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES,
    parameter int HALVES  = DEF_HALVES,
    parameter int ADDR_W  = $clog2(HALVES * PAGES * COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dglcd_cmd_if.sink         i_cmd,
    dglcd_rsp_if.source       o_rsp,
    output t_ram_ctl          o_ram_ctl,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [7:0]        o_ram_wdata,
    input  logic [7:0]        i_ram_rdata
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam t_mod_tab COL_MOD  = mod_table(COLUMNS);
    localparam t_mod_tab PAGE_MOD = mod_table(PAGES);

    t_state             r_state, n_state;
    logic [PAGE_W-1:0]  r_page  [HALVES];
    logic [PAGE_W-1:0]  n_page  [HALVES];
    logic [COL_W-1:0]   r_col   [HALVES];
    logic [COL_W-1:0]   n_col   [HALVES];
    logic [5:0]         r_line  [HALVES];
    logic [5:0]         n_line  [HALVES];
    logic               r_en    [HALVES];
    logic               n_en    [HALVES];
    logic [7:0]         r_latch [HALVES];
    logic [7:0]         n_latch [HALVES];
    logic               r_dummy [HALVES];
    logic               n_dummy [HALVES];
    logic               r_fill_half, n_fill_half;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;

    logic               acc;
    logic               present;
    t_mode              mode;
    t_ins               ins;
    logic [COL_W-1:0]   cur_col;
    logic [COL_W-1:0]   step_col;
    logic [COL_W-1:0]   rd_col;

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c);
        return (32'(c) + 1 == COLUMNS) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ram_addr(input logic h,
                                                  input logic [PAGE_W-1:0] p,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'((32'(h) * PAGES + 32'(p)) * COLUMNS + 32'(c));
    endfunction

    assign mode     = t_mode'(i_cmd.mode);
    assign ins      = decode_ins(i_cmd.bus_byte);
    assign present  = (HALVES > 1) || !i_cmd.chip;
    assign cur_col  = r_col[i_cmd.chip];
    assign step_col = col_inc(cur_col);
    assign rd_col   = r_dummy[i_cmd.chip] ? cur_col : step_col;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign acc         = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_state     = r_state;
        n_page      = r_page;
        n_col       = r_col;
        n_line      = r_line;
        n_en        = r_en;
        n_latch     = r_latch;
        n_dummy     = r_dummy;
        n_fill_half = r_fill_half;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_byte  = r_out_byte;
        o_ram_ctl   = '0;
        o_ram_addr  = ram_addr(i_cmd.chip, r_page[i_cmd.chip], cur_col);
        o_ram_wdata = i_cmd.bus_byte;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (mode)
                        MODE_INS_WR: begin
                            if (present) begin
                                unique case (ins)
                                    INS_DISPLAY: n_en[i_cmd.chip] = i_cmd.bus_byte[0];
                                    INS_COLUMN: begin
                                        n_col[i_cmd.chip] =
                                            COL_W'(COL_MOD[i_cmd.bus_byte[5:0]]);
                                        n_dummy[i_cmd.chip] = 1'b1;
                                    end
                                    INS_PAGE: begin
                                        n_page[i_cmd.chip] =
                                            PAGE_W'(PAGE_MOD[6'(i_cmd.bus_byte & ARG3_MASK)]);
                                        n_dummy[i_cmd.chip] = 1'b1;
                                    end
                                    INS_START: n_line[i_cmd.chip] =
                                        6'(i_cmd.bus_byte & ARG6_MASK);
                                    default: ;
                                endcase
                            end
                        end
                        MODE_DATA_WR: begin
                            if (present) begin
                                o_ram_ctl.we      = 1'b1;
                                n_col[i_cmd.chip] = step_col;
                            end
                        end
                        MODE_STATUS_RD: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = (present && !r_en[i_cmd.chip]) ? STAT_OFF : 8'h00;
                            n_out_byte  = n_out_byte & ~(STAT_BUSY | STAT_RESET);
                        end
                        MODE_DATA_RD: begin
                            n_out_valid = 1'b1;
                            if (present) begin
                                n_out_byte          = r_latch[i_cmd.chip];
                                n_dummy[i_cmd.chip] = 1'b0;
                                n_col[i_cmd.chip]   = rd_col;
                                o_ram_ctl.re        = 1'b1;
                                o_ram_addr  = ram_addr(i_cmd.chip, r_page[i_cmd.chip], rd_col);
                                n_fill_half = i_cmd.chip;
                                n_state     = S_FILL;
                            end else begin
                                n_out_byte = 8'h00;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                n_latch[r_fill_half] = i_ram_rdata;
                n_state              = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_page      <= '{default: '0};
            r_col       <= '{default: '0};
            r_line      <= '{default: '0};
            r_en        <= '{default: 1'b0};
            r_latch     <= '{default: '0};
            r_dummy     <= '{default: 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page      <= n_page;
            r_col       <= n_col;
            r_line      <= n_line;
            r_en        <= n_en;
            r_latch     <= n_latch;
            r_dummy     <= n_dummy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_half <= n_fill_half;
        r_out_byte  <= n_out_byte;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_byte = r_out_byte;

    // A data read on a present half is always followed by the latch refill state.
    a_read_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && mode == MODE_DATA_RD && present) |=> (r_state == S_FILL))
        else $error("data read did not enter latch refill");

    // No new access is taken while the latch refill is outstanding.
    a_fill_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !acc)
        else $error("access accepted during latch refill");

    // Every read produces a result word on the next cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cmd.mode[1]) |=> r_out_valid)
        else $error("read produced no result word");

    // Writes never produce a result word.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cmd.mode[1]) |=> !r_out_valid)
        else $error("write produced a result word");

endmodule

>>> hw/rtl/dual_chip_graphic_lcd_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_chip_graphic_lcd_controller_core
// Bus side of a two-half graphic LCD controller with display RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Fields                      Word
//   i_cmd     in    mode[1:0] chip bus_byte[7:0] one bus access
//   o_rsp     out   read_byte[7:0]              one read result
//
// Instruction writes, data writes and status reads complete in the idle
// state. A data read loads the result word at once from the read latch,
// then the refill state brings the byte from the single display RAM
// port back into the latch, during which no access is taken.
// An access is accepted only when the result register is empty or is being
// emptied in the same cycle, so a stalled reader holds off the bus.
// Reset is synchronous and active low; it clears the per-half registers
// (page, column, start line, display off, latch zero, dummy read pending).
// The display RAM itself has no reset and needs no clearing pass.
//
module dual_chip_graphic_lcd_controller_core
    import dglcd_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES,
    parameter int HALVES  = DEF_HALVES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dglcd_cmd_if.sink   i_cmd,
    dglcd_rsp_if.source o_rsp
);

    // One byte per column of every page of every half.
    localparam int DEPTH  = HALVES * PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_ram_ctl          ram_ctl;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // The controller decodes accesses, owns the per-half registers and the
    // result register, and drives the RAM port.
    dglcd_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .HALVES  (HALVES),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_ram_ctl   (ram_ctl),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    // The display RAM is addressed as half, page, column from high to low.
    dglcd_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule
